// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// All of them are clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/pm25aqi_pkg.sv
package pm25aqi_pkg;

  localparam int NUM_SEG     = 7;
  localparam int CONC_W      = 13;
  localparam int AQI_W       = 10;
  localparam int CAT_W       = 3;
  localparam int BASE_W      = 9;
  localparam int STEP_W      = 8;
  localparam int DIV_W       = 12;
  localparam int NUM_W       = 20;  // 2*d*span + width, at most 939200
  localparam int QUO_W       = 8;   // quotient never exceeds 235
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 13;
  localparam int SUM_W       = AQI_W + 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 4;
  localparam int CFG_IDX_W   = 2;

  typedef logic [CONC_W-1:0]  conc_t;
  typedef logic [AQI_W-1:0]   aqi_t;
  typedef logic [CAT_W-1:0]   cat_t;
  typedef logic [BASE_W-1:0]  base_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [DIV_W-1:0]   div_t;
  typedef logic [NUM_W-1:0]   num_t;
  typedef logic [QUO_W-1:0]   quo_t;
  typedef logic [RECIP_W-1:0] recip_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = CFG_IDX_W'(1);

  localparam conc_t LOW_LIMIT_RST  = CONC_W'(50);
  localparam conc_t HIGH_LIMIT_RST = CONC_W'(5505);
  localparam int    AQI_MAX        = 1023;

  // segment start, in tenths
  localparam conc_t SEG_LO [NUM_SEG] = '{
    CONC_W'(0), CONC_W'(120), CONC_W'(355), CONC_W'(555),
    CONC_W'(1505), CONC_W'(2505), CONC_W'(3505)
  };

  // segment width, in tenths
  localparam int SEG_WIDTH_I [NUM_SEG] = '{120, 235, 200, 950, 1000, 1000, 2000};

  localparam div_t SEG_WIDTH [NUM_SEG] = '{
    DIV_W'(SEG_WIDTH_I[0]), DIV_W'(SEG_WIDTH_I[1]), DIV_W'(SEG_WIDTH_I[2]),
    DIV_W'(SEG_WIDTH_I[3]), DIV_W'(SEG_WIDTH_I[4]), DIV_W'(SEG_WIDTH_I[5]),
    DIV_W'(SEG_WIDTH_I[6])
  };

  // divisor 2*width
  localparam div_t SEG_DIV [NUM_SEG] = '{
    DIV_W'(2 * SEG_WIDTH_I[0]), DIV_W'(2 * SEG_WIDTH_I[1]), DIV_W'(2 * SEG_WIDTH_I[2]),
    DIV_W'(2 * SEG_WIDTH_I[3]), DIV_W'(2 * SEG_WIDTH_I[4]), DIV_W'(2 * SEG_WIDTH_I[5]),
    DIV_W'(2 * SEG_WIDTH_I[6])
  };

  // floor(2^20 / (2*width)); estimate is low by at most one
  localparam recip_t SEG_RECIP [NUM_SEG] = '{
    RECIP_W'((1 << RECIP_SHIFT) / (2 * SEG_WIDTH_I[0])),
    RECIP_W'((1 << RECIP_SHIFT) / (2 * SEG_WIDTH_I[1])),
    RECIP_W'((1 << RECIP_SHIFT) / (2 * SEG_WIDTH_I[2])),
    RECIP_W'((1 << RECIP_SHIFT) / (2 * SEG_WIDTH_I[3])),
    RECIP_W'((1 << RECIP_SHIFT) / (2 * SEG_WIDTH_I[4])),
    RECIP_W'((1 << RECIP_SHIFT) / (2 * SEG_WIDTH_I[5])),
    RECIP_W'((1 << RECIP_SHIFT) / (2 * SEG_WIDTH_I[6]))
  };

  // index at segment start
  localparam base_t SEG_BASE [NUM_SEG] = '{
    BASE_W'(0), BASE_W'(50), BASE_W'(100), BASE_W'(150),
    BASE_W'(200), BASE_W'(300), BASE_W'(400)
  };

  // index span across the segment
  localparam base_t SEG_SPAN [NUM_SEG] = '{
    BASE_W'(50), BASE_W'(50), BASE_W'(50), BASE_W'(50),
    BASE_W'(100), BASE_W'(100), BASE_W'(100)
  };

  // 2*span
  localparam step_t SEG_STEP2 [NUM_SEG] = '{
    STEP_W'(100), STEP_W'(100), STEP_W'(100), STEP_W'(100),
    STEP_W'(200), STEP_W'(200), STEP_W'(200)
  };

  localparam cat_t CAT_TOP = CAT_W'(NUM_SEG - 1);

  typedef struct packed {
    conc_t d;
    cat_t  cat;
    logic  outl;
  } s1_t;

  typedef struct packed {
    num_t n;
    cat_t cat;
    logic outl;
  } s2_t;

  typedef struct packed {
    num_t n;
    quo_t qe;
    cat_t cat;
    logic outl;
  } s3_t;

  typedef struct packed {
    aqi_t aqi;
    cat_t cat;
    logic outl;
  } s4_t;

endpackage

// File: rtl/pm25_aqi_classifier_top.sv
// Pipeline: four register stages, the first loaded at the input accept edge;
//   out_tvalid rises when the item reaches the fourth, later under an output stall.
// Throughput: one item per cycle while the output is not stalled; the path is four registered
//   stages, the deepest being the 20x13 reciprocal multiply that forms the quotient.
// Reset (rst_n low at a clock edge, synchronous): all stage valid bits clear,
//   outlier limits return to 50 and 5505 tenths. Payload is not reset.
module pm25_aqi_classifier_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input item stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pm25aqi_pkg::IN_TDATA_W-1:0]    in_tdata,   // [12:0] conc_tenths
  // result item stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pm25aqi_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] aqi_value
  output logic [pm25aqi_pkg::OUT_TUSER_W-1:0]   out_tuser,  // [2:0] category, [3] is_outlier
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pm25aqi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pm25aqi_pkg::CONC_W-1:0]        cfg_data
);
  import pm25aqi_pkg::*;

`include "assert_macros.svh"

  // ---------------------------------------------------------------------
  // Configuration registers. Writes always accepted; unknown index dropped.
  // ---------------------------------------------------------------------
  conc_t low_lim_r, high_lim_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_lim_r  <= LOW_LIMIT_RST;
      high_lim_r <= HIGH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_LIMIT:  low_lim_r  <= cfg_data;
        REG_HIGH_LIMIT: high_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage handshake. Each stage loads when it is empty or its successor
  // moves, so a stall backs up without losing or repeating an item.
  // ---------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: segment search, offset into segment, outlier test.
  // ---------------------------------------------------------------------
  conc_t conc;
  cat_t  seg;
  s1_t   s1_nxt, s1_r;

  assign conc = in_tdata[CONC_W-1:0];

  always_comb begin
    seg = '0;
    // breakpoints ascend, so the last one passed is the segment
    for (int i = 1; i < NUM_SEG; i++) begin
      if (conc >= SEG_LO[i]) seg = CAT_W'(i);
    end
    s1_nxt.cat  = seg;
    s1_nxt.d    = conc - SEG_LO[seg];
    s1_nxt.outl = (conc < low_lim_r) || (conc > high_lim_r);
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) s1_r <= s1_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 2: numerator 2*d*span + width (rounding offset folded in).
  // ---------------------------------------------------------------------
  logic [NUM_W:0] nmul;
  s2_t            s2_nxt, s2_r;

  always_comb begin
    nmul        = (NUM_W+1)'(s1_r.d) * (NUM_W+1)'(SEG_STEP2[s1_r.cat]);
    s2_nxt.n    = NUM_W'(nmul + (NUM_W+1)'(SEG_WIDTH[s1_r.cat]));
    s2_nxt.cat  = s1_r.cat;
    s2_nxt.outl = s1_r.outl;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) s2_r <= s2_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 3: quotient estimate by reciprocal multiply, low by 0 or 1.
  // ---------------------------------------------------------------------
  logic [NUM_W+RECIP_W-1:0] qmul;
  s3_t                      s3_nxt, s3_r;

  always_comb begin
    qmul        = (NUM_W+RECIP_W)'(s2_r.n) * (NUM_W+RECIP_W)'(SEG_RECIP[s2_r.cat]);
    s3_nxt.n    = s2_r.n;
    s3_nxt.qe   = qmul[RECIP_SHIFT +: QUO_W];
    s3_nxt.cat  = s2_r.cat;
    s3_nxt.outl = s2_r.outl;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) s3_r <= s3_nxt;
  end

  // ---------------------------------------------------------------------
  // Stage 4: remainder check and correction, add segment base, saturate.
  // ---------------------------------------------------------------------
  num_t           back, rem;
  logic           corr;
  logic [SUM_W-1:0] sum;
  s4_t            s4_nxt, s4_r;

  always_comb begin
    back        = NUM_W'(s3_r.qe) * NUM_W'(SEG_DIV[s3_r.cat]);
    rem         = s3_r.n - back;
    corr        = rem >= NUM_W'(SEG_DIV[s3_r.cat]);
    sum         = SUM_W'(SEG_BASE[s3_r.cat]) + SUM_W'(s3_r.qe) + SUM_W'(corr);
    s4_nxt.aqi  = (sum > SUM_W'(AQI_MAX)) ? AQI_W'(AQI_MAX) : sum[AQI_W-1:0];
    s4_nxt.cat  = s3_r.cat;
    s4_nxt.outl = s3_r.outl;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) s4_r <= s4_nxt;
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = OUT_TDATA_W'(s4_r.aqi);
  assign out_tuser  = {s4_r.outl, s4_r.cat};

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  logic rem_ok;
  logic aqi_in_seg;
  logic take_full;

  // remainder must stay below twice the divisor or one correction is too few
  assign rem_ok = {1'b0, rem} < ((NUM_W+1)'(SEG_DIV[s3_r.cat]) << 1);

  // below the top segment the index stays inside its segment's range
  assign aqi_in_seg = (s4_r.cat == CAT_TOP) ||
                      ((SUM_W'(s4_r.aqi) >= SUM_W'(SEG_BASE[s4_r.cat])) &&
                       (SUM_W'(s4_r.aqi) <= SUM_W'(SEG_BASE[s4_r.cat]) +
                                            SUM_W'(SEG_SPAN[s4_r.cat])));

  // input item taken while every stage holds an item
  assign take_full = in_tvalid && in_tready && v1_r && v2_r && v3_r && v4_r;

  `ASSERT_IMPL(a_rem_bound, v3_r, rem_ok, "quotient estimate off by more than one")
  `ASSERT_IMPL(a_aqi_range, v4_r, aqi_in_seg, "index outside its category range")
  `ASSERT_IMPL(a_full_accept, take_full, out_tready, "item taken into a full stalled pipeline")

endmodule
